>>> sv/sdsq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the sprite depth-sort queue.
// No dependencies; imported by the controller, the datapath and the top level.
package sdsq_pkg;

  localparam int LIST_DEPTH_DEF = 64;

  // Request actions
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_DRAIN  = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_INSERTED = 3'd0;
  localparam logic [2:0] KIND_CULLED   = 3'd1;
  localparam logic [2:0] KIND_DROPPED  = 3'd2;
  localparam logic [2:0] KIND_CLEARED  = 3'd3;
  localparam logic [2:0] KIND_ENTRY    = 3'd4;
  localparam logic [2:0] KIND_EMPTY    = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_VIEW_X = 2'd0;
  localparam logic [1:0] CFG_VIEW_Y = 2'd1;
  localparam logic [1:0] CFG_VIEW_W = 2'd2;
  localparam logic [1:0] CFG_VIEW_H = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [15:0]        sprite_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [10:0]        anchor_x;
    logic [10:0]        anchor_y;
    logic [10:0]        frame_w;
    logic [10:0]        frame_h;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [15:0]        out_sprite;
    logic [10:0]        dest_x;
    logic [10:0]        dest_y;
    logic [10:0]        dest_w;
    logic [10:0]        dest_h;
    logic signed [15:0] depth_key;
    logic               last;
  } out_item_t;

  // Link-memory write selections
  typedef enum logic [2:0] {
    NXW_NONE,
    NXW_SLOT_NULL,  // next[slot] = 0
    NXW_SLOT_HEAD,  // next[slot] = head
    NXW_SLOT_CUR,   // next[slot] = next[cur]
    NXW_CUR_SLOT    // next[cur]  = slot
  } nxw_t;

  typedef struct packed {
    logic       item_load;
    logic       pay_key_we;
    nxw_t       nxw;
    logic       rd_en;
    logic       rd_next;      // 0: read at head, 1: read at fetched next link
    logic       head_to_slot;
    logic       used_inc;
    logic       list_reset;
    logic       walk_start;
    logic       walk_adv;
    logic       cnt_set_one;
    logic       cnt_used;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       out_entry;
    logic       out_resp;
    logic [2:0] resp_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       cull;
    logic       full;
    logic       empty;
    logic       used_one;
    logic       head_gt;
    logic       walk_stop;
    logic       walk_end;
    logic       cnt_one;
    logic       out_free;
  } dp_sts_t;

endpackage

>>> sv/sprite_depth_sort_queue.sv
`timescale 1ns / 1ps
// Sprite depth-sort queue, top level: per-frame draw list kept in y-key order.
// Depends on sdsq_pkg, sdsq_ctrl and sdsq_datapath.
//
// Usage:
//   Requests enter on in_valid/in_ready with an in_item_t payload: clear,
//   insert a sprite, or drain the list. Action code 3 is taken and ignored.
//   Results leave on out_valid/out_ready as out_item_t; every request except
//   the ignored one ends with a result whose last bit is set.
//   The view window is written on cfg_valid/cfg_ready (always ready) at
//   index cfg_index; write it only while no request is in flight.
// Timing:
//   One request is worked on at a time; in_ready is high only when idle.
//   Clear and culled/dropped inserts: the result is loaded in the response
//   state after dispatch and, for inserts, the clip states. An insert that
//   links walks the list one entry per cycle through the single read port
//   of the slot memories. A drain fetches the head entry, then emits one
//   entry per cycle while the result register is free.
// Reset and stall:
//   rst_n (synchronous, active low) empties the list and restores the view
//   window to 0, 0, 320 x 240. Slot memories are not cleared; only linked
//   slots are ever read. The result register holds while out_ready is low;
//   a drain pauses on the entry in hand and resumes when the register frees.
module sprite_depth_sort_queue
  import sdsq_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Register writes never stall.
  assign cfg_ready = 1'b1;

  sdsq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sdsq_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> sv/sdsq_ctrl.sv
`timescale 1ns / 1ps
// Controller of the sprite depth-sort queue: sequences clear, clip, insert walk and drain.
// Depends on sdsq_pkg; drives the datapath through dp_cmd_t, reads dp_sts_t.
module sdsq_ctrl
  import sdsq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CLIP_B,
    ST_CLIP_C,
    ST_INS_DEC,
    ST_INS_HEAD,
    ST_INS_WALK,
    ST_LINK1,
    ST_LINK2,
    ST_DR_EMIT,
    ST_RESP
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] resp_kind_r, resp_kind_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    resp_kind_nxt = resp_kind_r;
    cmd           = '0;
    cmd.nxw       = NXW_NONE;
    cmd.resp_kind = resp_kind_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_nxt     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts.action)
          ACT_CLEAR: begin
            cmd.list_reset = 1'b1;
            resp_kind_nxt  = KIND_CLEARED;
            state_nxt      = ST_RESP;
          end
          ACT_INSERT: state_nxt = ST_CLIP_B;
          ACT_DRAIN: begin
            if (sts.empty) begin
              resp_kind_nxt = KIND_EMPTY;
              state_nxt     = ST_RESP;
            end else begin
              cmd.rd_en    = 1'b1;
              cmd.cnt_used = 1'b1;
              state_nxt    = ST_DR_EMIT;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_CLIP_B: state_nxt = ST_CLIP_C;
      ST_CLIP_C: state_nxt = ST_INS_DEC;
      ST_INS_DEC: begin
        if (sts.cull) begin
          resp_kind_nxt = KIND_CULLED;
          state_nxt     = ST_RESP;
        end else if (sts.full) begin
          resp_kind_nxt = KIND_DROPPED;
          state_nxt     = ST_RESP;
        end else begin
          cmd.pay_key_we = 1'b1;
          if (sts.empty) begin
            cmd.nxw          = NXW_SLOT_NULL;
            cmd.head_to_slot = 1'b1;
            cmd.used_inc     = 1'b1;
            resp_kind_nxt    = KIND_INSERTED;
            state_nxt        = ST_RESP;
          end else begin
            cmd.rd_en = 1'b1;
            state_nxt = ST_INS_HEAD;
          end
        end
      end
      ST_INS_HEAD: begin
        if (sts.head_gt) begin
          cmd.nxw          = NXW_SLOT_HEAD;
          cmd.head_to_slot = 1'b1;
          cmd.used_inc     = 1'b1;
          resp_kind_nxt    = KIND_INSERTED;
          state_nxt        = ST_RESP;
        end else begin
          cmd.walk_start = 1'b1;
          if (sts.used_one) begin
            state_nxt = ST_LINK1;
          end else begin
            cmd.cnt_set_one = 1'b1;
            cmd.rd_en       = 1'b1;
            cmd.rd_next     = 1'b1;
            state_nxt       = ST_INS_WALK;
          end
        end
      end
      ST_INS_WALK: begin
        if (sts.walk_stop) begin
          state_nxt = ST_LINK1;
        end else begin
          cmd.walk_adv = 1'b1;
          if (sts.walk_end) begin
            state_nxt = ST_LINK1;
          end else begin
            cmd.cnt_inc = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_next = 1'b1;
          end
        end
      end
      ST_LINK1: begin
        cmd.nxw   = NXW_SLOT_CUR;
        state_nxt = ST_LINK2;
      end
      ST_LINK2: begin
        cmd.nxw       = NXW_CUR_SLOT;
        cmd.used_inc  = 1'b1;
        resp_kind_nxt = KIND_INSERTED;
        state_nxt     = ST_RESP;
      end
      ST_DR_EMIT: begin
        if (sts.out_free) begin
          cmd.out_entry = 1'b1;
          if (sts.cnt_one) begin
            cmd.list_reset = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            cmd.cnt_dec = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_next = 1'b1;
          end
        end
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.out_resp = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      resp_kind_r <= KIND_INSERTED;
    end else begin
      state_r     <= state_nxt;
      resp_kind_r <= resp_kind_nxt;
    end
  end

endmodule

>>> sv/sdsq_datapath.sv
`timescale 1ns / 1ps
// Datapath of the sprite depth-sort queue: view registers, clip pipeline,
// slot memories, list pointers and the result register. Depends on sdsq_pkg.
module sdsq_datapath
  import sdsq_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data,
  input  in_item_t  in_data,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_data,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts
);

  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  typedef logic signed [17:0] crd_t;

  typedef struct packed {
    logic [10:0] dh;
    logic [10:0] dw;
    logic [10:0] dy;
    logic [10:0] dx;
  } rect_t;

  typedef struct packed {
    logic [15:0] sprite;
    rect_t       rect;
  } pay_t;

  // View window
  logic [14:0] view_x_r, view_y_r;
  logic [10:0] view_w_r, view_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_x_r <= '0;
      view_y_r <= '0;
      view_w_r <= 11'd320;
      view_h_r <= 11'd240;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_VIEW_X: view_x_r <= cfg_data;
        CFG_VIEW_Y: view_y_r <= cfg_data;
        CFG_VIEW_W: view_w_r <= cfg_data[10:0];
        CFG_VIEW_H: view_h_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Request hold
  in_item_t item_r;
  always_ff @(posedge clk) begin
    if (cmd.item_load) item_r <= in_data;
  end

  // Clip pipeline, free running on the held request
  crd_t vx0, vy0;
  assign vx0 = $signed({3'd0, view_x_r});
  assign vy0 = $signed({3'd0, view_y_r});

  crd_t ax0_a_r, ay0_a_r, vx1_a_r, vy1_a_r;
  logic zero_a_r;
  crd_t x0_b_r, y0_b_r, x1_b_r, y1_b_r;
  logic zero_b_r;
  logic  cull_r;
  rect_t rect_r;

  crd_t ax1_b, ay1_b;
  crd_t dx_c, dy_c, dw_c, dh_c;

  always_comb begin
    ax1_b = ax0_a_r + $signed({7'd0, item_r.frame_w});
    ay1_b = ay0_a_r + $signed({7'd0, item_r.frame_h});
    dx_c  = x0_b_r - vx0;
    dy_c  = y0_b_r - vy0;
    dw_c  = x1_b_r - x0_b_r;
    dh_c  = y1_b_r - y0_b_r;
  end

  always_ff @(posedge clk) begin
    ax0_a_r  <= $signed({{2{item_r.pos_x[15]}}, item_r.pos_x})
              - $signed({7'd0, item_r.anchor_x});
    ay0_a_r  <= $signed({{2{item_r.pos_y[15]}}, item_r.pos_y})
              - $signed({7'd0, item_r.anchor_y});
    vx1_a_r  <= vx0 + $signed({7'd0, view_w_r});
    vy1_a_r  <= vy0 + $signed({7'd0, view_h_r});
    zero_a_r <= (item_r.frame_w == '0) || (item_r.frame_h == '0)
             || (view_w_r == '0) || (view_h_r == '0);

    x0_b_r   <= (ax0_a_r > vx0) ? ax0_a_r : vx0;
    y0_b_r   <= (ay0_a_r > vy0) ? ay0_a_r : vy0;
    x1_b_r   <= (ax1_b < vx1_a_r) ? ax1_b : vx1_a_r;
    y1_b_r   <= (ay1_b < vy1_a_r) ? ay1_b : vy1_a_r;
    zero_b_r <= zero_a_r;

    cull_r    <= zero_b_r || (x1_b_r <= x0_b_r) || (y1_b_r <= y0_b_r);
    rect_r.dx <= dx_c[10:0];
    rect_r.dy <= dy_c[10:0];
    rect_r.dw <= dw_c[10:0];
    rect_r.dh <= dh_c[10:0];
  end

  // List pointers
  logic [CW-1:0] used_r, cnt_r;
  logic [IW-1:0] head_r, cur_r, curnext_r;
  logic [IW-1:0] slot;
  assign slot = used_r[IW-1:0];

  // Slot memories
  pay_t               pay_mem  [LIST_DEPTH];
  logic signed [15:0] key_mem  [LIST_DEPTH];
  logic [IW-1:0]      next_mem [LIST_DEPTH];

  pay_t               pay_q;
  logic signed [15:0] key_q;
  logic [IW-1:0]      next_q;

  logic [IW-1:0] rd_addr;
  logic          nx_we;
  logic [IW-1:0] nx_waddr, nx_wdata;

  assign rd_addr = cmd.rd_next ? next_q : head_r;

  always_comb begin
    nx_we    = 1'b1;
    nx_waddr = slot;
    nx_wdata = '0;
    case (cmd.nxw)
      NXW_SLOT_NULL: nx_wdata = '0;
      NXW_SLOT_HEAD: nx_wdata = head_r;
      NXW_SLOT_CUR:  nx_wdata = curnext_r;
      NXW_CUR_SLOT: begin
        nx_waddr = cur_r;
        nx_wdata = slot;
      end
      default: nx_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.pay_key_we) begin
      pay_mem[slot] <= '{sprite: item_r.sprite_id, rect: rect_r};
      key_mem[slot] <= item_r.pos_y;
    end
    if (nx_we) next_mem[nx_waddr] <= nx_wdata;
    if (cmd.rd_en) begin
      pay_q  <= pay_mem[rd_addr];
      key_q  <= key_mem[rd_addr];
      next_q <= next_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      head_r    <= '0;
      cur_r     <= '0;
      curnext_r <= '0;
      cnt_r     <= '0;
    end else begin
      if (cmd.list_reset) begin
        used_r <= '0;
        head_r <= '0;
      end else begin
        if (cmd.used_inc) used_r <= used_r + CW'(1);
        if (cmd.head_to_slot) head_r <= slot;
      end
      if (cmd.walk_start) begin
        cur_r     <= head_r;
        curnext_r <= next_q;
      end else if (cmd.walk_adv) begin
        cur_r     <= curnext_r;
        curnext_r <= next_q;
      end
      if (cmd.cnt_set_one)   cnt_r <= CW'(1);
      else if (cmd.cnt_used) cnt_r <= used_r;
      else if (cmd.cnt_inc)  cnt_r <= cnt_r + CW'(1);
      else if (cmd.cnt_dec)  cnt_r <= cnt_r - CW'(1);
    end
  end

  // Result register
  logic      out_valid_r;
  out_item_t out_r;
  logic      out_free;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_entry || cmd.out_resp) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_entry) begin
      out_r.kind       <= KIND_ENTRY;
      out_r.out_sprite <= pay_q.sprite;
      out_r.dest_x     <= pay_q.rect.dx;
      out_r.dest_y     <= pay_q.rect.dy;
      out_r.dest_w     <= pay_q.rect.dw;
      out_r.dest_h     <= pay_q.rect.dh;
      out_r.depth_key  <= key_q;
      out_r.last       <= (cnt_r == CW'(1));
    end else if (cmd.out_resp) begin
      out_r <= '{kind: cmd.resp_kind, out_sprite: 16'd0, dest_x: 11'd0, dest_y: 11'd0,
                 dest_w: 11'd0, dest_h: 11'd0, depth_key: 16'sd0, last: 1'b1};
    end
  end

  // Status
  always_comb begin
    sts.action    = item_r.action;
    sts.cull      = cull_r;
    sts.full      = (used_r == CW'(LIST_DEPTH));
    sts.empty     = (used_r == '0);
    sts.used_one  = (used_r == CW'(1));
    sts.head_gt   = (key_q > item_r.pos_y);
    sts.walk_stop = (key_q >= item_r.pos_y);
    sts.walk_end  = ((cnt_r + CW'(1)) == used_r);
    sts.cnt_one   = (cnt_r == CW'(1));
    sts.out_free  = out_free;
  end

endmodule

>>> tb/tb_sprite_depth_sort_queue.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sprite depth-sort queue: predicts draw-list results in SV.
// Depends on sdsq_pkg and sprite_depth_sort_queue; no files or arguments are read.
module tb_sprite_depth_sort_queue;
  import sdsq_pkg::*;

  localparam int LIST_DEPTH    = LIST_DEPTH_DEF;
  // Extra wait after settling; set well past the longest walk of an insert.
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT   = 600000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_VIEW_X;
  logic [14:0] cfg_data  = '0;

  sprite_depth_sort_queue #(.LIST_DEPTH(LIST_DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Requests still to be sent, and draw-list results the block owes us.
  in_item_t  queued_requests[$];
  out_item_t results_due[$];
  // Rows of sprites queued in the current frame; reused to force equal depth keys.
  in_item_t  row_pool[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int issued_count   = 0;
  bit no_stall       = 1'b0;

  // View window as the block should hold it.
  int view_left   = 0;
  int view_top    = 0;
  int view_width  = 320;
  int view_height = 240;

  // Our own copy of the draw list: slots filled in arrival order, linked by key.
  out_item_t slot_entry[LIST_DEPTH];
  int        slot_key[LIST_DEPTH];
  int        slot_link[LIST_DEPTH];
  int        list_head = 0;
  int        list_used = 0;

  // Apply one accepted request to the draw list and queue the results it owes.
  function automatic void advance_draw_list(in_item_t req);
    out_item_t res;
    int px, py, ax0, ay0, ax1, ay1, vx1, vy1, x0, y0, x1, y1;
    int slot, cur, nx, k;
    res = '0;
    res.last = 1'b1;
    case (req.action)
      ACT_CLEAR: begin
        list_used = 0;
        list_head = 0;
        res.kind = KIND_CLEARED;
        results_due.push_back(res);
      end
      ACT_DRAIN: begin
        if (list_used == 0) begin
          res.kind = KIND_EMPTY;
          results_due.push_back(res);
        end else begin
          cur = list_head;
          for (k = 0; k < list_used; k++) begin
            res = slot_entry[cur];
            res.kind = KIND_ENTRY;
            res.last = (k == list_used - 1);
            results_due.push_back(res);
            cur = slot_link[cur];
          end
          list_used = 0;
          list_head = 0;
        end
      end
      ACT_INSERT: begin
        px  = req.pos_x;
        py  = req.pos_y;
        ax0 = px - int'(req.anchor_x);
        ay0 = py - int'(req.anchor_y);
        ax1 = ax0 + int'(req.frame_w);
        ay1 = ay0 + int'(req.frame_h);
        vx1 = view_left + view_width;
        vy1 = view_top + view_height;
        x0  = (ax0 > view_left) ? ax0 : view_left;
        y0  = (ay0 > view_top) ? ay0 : view_top;
        x1  = (ax1 < vx1) ? ax1 : vx1;
        y1  = (ay1 < vy1) ? ay1 : vy1;
        if (req.frame_w == 0 || req.frame_h == 0 || view_width == 0 || view_height == 0 ||
            x1 <= x0 || y1 <= y0) begin
          res.kind = KIND_CULLED;
        end else if (list_used >= LIST_DEPTH) begin
          res.kind = KIND_DROPPED;
        end else begin
          slot = list_used;
          slot_entry[slot] = '0;
          slot_entry[slot].out_sprite = req.sprite_id;
          slot_entry[slot].dest_x     = 11'(x0 - view_left);
          slot_entry[slot].dest_y     = 11'(y0 - view_top);
          slot_entry[slot].dest_w     = 11'(x1 - x0);
          slot_entry[slot].dest_h     = 11'(y1 - y0);
          slot_entry[slot].depth_key  = req.pos_y;
          slot_key[slot]  = py;
          slot_link[slot] = 0;
          if (list_used == 0) begin
            list_head = slot;
          end else if (slot_key[list_head] > py) begin
            slot_link[slot] = list_head;
            list_head = slot;
          end else begin
            // A tie with the head lands behind it; deeper ties land ahead of equals.
            cur = list_head;
            for (k = 1; k < list_used; k++) begin
              nx = slot_link[cur];
              if (slot_key[nx] >= py) break;
              cur = nx;
            end
            slot_link[slot] = slot_link[cur];
            slot_link[cur]  = slot;
          end
          list_used++;
          res.kind = KIND_INSERTED;
        end
        results_due.push_back(res);
      end
      default: ; // unused action: taken, no result
    endcase
  endfunction

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Random payload with the given action; the block ignores the sprite fields
  // of clear and drain, so they toggle freely here.
  function automatic in_item_t random_request(logic [1:0] act);
    in_item_t r;
    r = in_item_t'({$urandom, $urandom, $urandom});
    r.action = act;
    return r;
  endfunction

  // Sprite aimed around the current view, sometimes sharing a row's key.
  function automatic in_item_t make_sprite();
    in_item_t s;
    int fw, fh, ax, ay, pick;
    s = random_request(ACT_INSERT);
    if ($urandom_range(0, 9) == 0) begin
      fw = $urandom_range(1, 2047);
      ax = $urandom_range(0, 2047);
    end else begin
      fw = $urandom_range(1, 64);
      ax = $urandom_range(0, 63);
    end
    if ($urandom_range(0, 9) == 0) begin
      fh = $urandom_range(1, 2047);
      ay = $urandom_range(0, 2047);
    end else begin
      fh = $urandom_range(1, 64);
      ay = $urandom_range(0, 63);
    end
    s.frame_w  = 11'(fw);
    s.anchor_x = 11'(ax);
    s.frame_h  = 11'(fh);
    s.anchor_y = 11'(ay);
    s.pos_x = 16'(clamp16(view_left + int'($urandom_range(0, view_width + 32)) - 16 - fw / 2
                          + ax));
    s.pos_y = 16'(clamp16(view_top + int'($urandom_range(0, view_height + 32)) - 16 - fh / 2
                          + ay));
    if (row_pool.size() > 0 && $urandom_range(0, 2) == 0) begin
      pick = $urandom_range(0, row_pool.size() - 1);
      s.pos_y    = row_pool[pick].pos_y;
      s.anchor_y = row_pool[pick].anchor_y;
      s.frame_h  = row_pool[pick].frame_h;
    end
    row_pool.push_back(s);
    return s;
  endfunction

  function automatic void push_request(in_item_t r);
    queued_requests.push_back(r);
    issued_count++;
  endfunction

  function automatic void push_insert(int id, int px, int py, int ax, int ay, int fw, int fh);
    in_item_t r;
    r = '0;
    r.action    = ACT_INSERT;
    r.sprite_id = 16'(id);
    r.pos_x     = 16'(px);
    r.pos_y     = 16'(py);
    r.anchor_x  = 11'(ax);
    r.anchor_y  = 11'(ay);
    r.frame_w   = 11'(fw);
    r.frame_h   = 11'(fh);
    push_request(r);
  endfunction

  // One frame: usually a clear, a burst of sprites with some noise, then a drain.
  // Long bursts overrun the list so that full-list drops appear.
  function automatic void queue_frame();
    int n, size_class;
    row_pool.delete();
    if ($urandom_range(0, 4) != 0) push_request(random_request(ACT_CLEAR));
    size_class = $urandom_range(0, 9);
    if (size_class < 7) n = $urandom_range(1, 12);
    else if (size_class < 9) n = $urandom_range(13, 40);
    else n = $urandom_range(66, 80);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0)
        push_request(random_request(2'($urandom_range(0, 3))));
      else
        push_request(make_sprite());
    end
    if ($urandom_range(0, 9) != 0) push_request(random_request(ACT_DRAIN));
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want_v,
                                      logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  // Request driver: hold a pending request until taken, otherwise idle at random.
  always @(posedge clk) begin : drive_requests
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) advance_draw_list(in_data);
      if (in_valid && !in_ready) begin
        // hold the request and its payload
      end else if (queued_requests.size() > 0 && (no_stall || $urandom_range(0, 99) >= 27)) begin
        in_valid <= 1'b1;
        in_data  <= queued_requests.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor: compare each taken result with the oldest one owed.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("unexpected result: kind %0d sprite %0d", out_data.kind, out_data.out_sprite);
          mismatch_count++;
        end else begin
          want = results_due.pop_front();
          check_field("kind", want.kind, out_data.kind);
          check_field("out_sprite", want.out_sprite, out_data.out_sprite);
          check_field("dest_x", want.dest_x, out_data.dest_x);
          check_field("dest_y", want.dest_y, out_data.dest_y);
          check_field("dest_w", want.dest_w, out_data.dest_w);
          check_field("dest_h", want.dest_h, out_data.dest_h);
          check_field("depth_key", want.depth_key, out_data.depth_key);
          check_field("last", want.last, out_data.last);
        end
      end
      out_ready <= no_stall || $urandom_range(0, 99) >= 27;
    end
  end

  // Watchdog: end the run if it stalls.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sprite_depth_sort_queue test failed");
      $finish;
    end
  end

  // Wait until every request is sent and every owed result has come, then let
  // the block finish any request that owes nothing.
  task automatic settle();
    do @(posedge clk); while (queued_requests.size() != 0 || in_valid || results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_view(logic [1:0] idx, int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 15'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_VIEW_X: view_left   = value & 32'h7FFF;
      CFG_VIEW_Y: view_top    = value & 32'h7FFF;
      CFG_VIEW_W: view_width  = value & 32'h7FF;
      CFG_VIEW_H: view_height = value & 32'h7FF;
      default: ;
    endcase
  endtask

  task automatic set_view(int x, int y, int w, int h);
    write_view(CFG_VIEW_X, x);
    write_view(CFG_VIEW_Y, y);
    write_view(CFG_VIEW_W, w);
    write_view(CFG_VIEW_H, h);
  endtask

  task automatic random_phase(int target);
    int start;
    start = issued_count;
    while (issued_count - start < target) queue_frame();
    settle();
  endtask

  initial begin : run_test
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass on the reset view window (0, 0, 320 x 240).
    push_request(random_request(ACT_DRAIN));            // drain of an empty list
    push_request(random_request(ACT_CLEAR));
    push_insert(16'h0001, 50, 50, 0, 0, 0, 10);         // zero width: culled
    push_insert(16'h0001, 50, 50, 0, 0, 10, 0);         // zero height: culled
    push_insert(16'hFFFF, 100, 100, 10, 10, 20, 20);    // first entry becomes head
    push_insert(16'h0002, 150, 100, 0, 0, 8, 8);        // tie with head: goes behind
    push_insert(16'h0003, 60, 50, 4, 4, 16, 16);        // smaller key: new head
    push_insert(16'h0004, 200, 100, 0, 0, 4, 4);        // tie past head: ahead of equals
    push_insert(16'h0005, -5, -5, 0, 0, 10, 10);        // clipped at top-left
    push_insert(16'h0006, 315, 235, 0, 0, 2047, 2047);  // clipped at bottom-right
    push_insert(16'h0007, 320, 10, 0, 0, 10, 10);       // touches right edge: culled
    push_insert(16'h0008, 10, 240, 0, 0, 10, 10);       // touches bottom edge: culled
    push_insert(16'h0009, -32768, -32768, 2047, 2047, 2047, 2047);
    push_insert(16'h000A, 32767, 32767, 0, 0, 2047, 2047);
    push_insert(16'h0000, 2047, 2047, 2047, 2047, 2047, 2047); // covers the whole view
    push_request(random_request(2'd3));                 // unused action
    push_request(random_request(ACT_DRAIN));
    push_request(random_request(ACT_DRAIN));
    push_insert(16'h8000, 0, 0, 0, 0, 1, 1);            // one-pixel sprite at the origin
    push_request(random_request(ACT_CLEAR));            // clear a non-empty list
    settle();

    // Largest view at the origin: most sprites land, long frames fill the list.
    set_view(0, 0, 2047, 2047);
    random_phase(85);

    // Far corner of the world, with neither side idling.
    no_stall = 1'b1;
    set_view(32767, 32767, 2047, 2047);
    random_phase(75);
    no_stall = 1'b0;

    // Degenerate windows: zero width, then zero height.
    set_view(0, 32767, 0, 240);
    random_phase(10);
    set_view($urandom_range(0, 32767), 0, 500, 0);
    random_phase(10);

    repeat (3) begin
      set_view($urandom_range(0, 32767), $urandom_range(0, 32767),
               $urandom_range(16, 2047), $urandom_range(16, 2047));
      random_phase(45);
    end

    settle();
    if (mismatch_count == 0 && results_due.size() == 0)
      $display("sprite_depth_sort_queue test passed");
    else
      $display("sprite_depth_sort_queue test failed");
    $finish;
  end

endmodule

>>> filelist.f
sv/sdsq_pkg.sv
sv/sdsq_ctrl.sv
sv/sdsq_datapath.sv
sv/sprite_depth_sort_queue.sv
tb/tb_sprite_depth_sort_queue.sv
